/* sv/otsu_threshold_finder_top_assert.svh */
// Assertion shorthands used by the checker in otsu_chk.sv.
`ifndef OTSU_THRESHOLD_FINDER_TOP_ASSERT_SVH
`define OTSU_THRESHOLD_FINDER_TOP_ASSERT_SVH

// same-cycle implication
`define OTSU_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define OTSU_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/otsu_pkg.sv */
package otsu_pkg;

	localparam int unsigned LEVELS           = 256;
	localparam int unsigned LEVEL_W          = 8;
	localparam logic [LEVEL_W-1:0] LAST_LEVEL = LEVEL_W'(LEVELS - 1);
	localparam int unsigned PIX_CNT_BITS_DEF = 22;
	localparam int unsigned MUL_DIGIT_W      = 8;
	localparam int unsigned QDEPTH           = 4;

	typedef struct packed {
		logic [LEVEL_W-1:0] pixel_value;
		logic               last_pixel;
	} pix_item_t;

	typedef struct packed {
		logic      valid;
		pix_item_t item;
	} q_head_t;

	typedef struct packed {
		logic               rd_en;
		logic [LEVEL_W-1:0] rd_addr;
		logic               done;
		logic [LEVEL_W-1:0] threshold;
	} srch_stat_t;

endpackage

/* sv/otsu_pix_if.sv */
interface otsu_pix_if import otsu_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [LEVEL_W-1:0] pixel_value;
	logic               last_pixel;

	modport source(output valid, output pixel_value, output last_pixel, input ready);
	modport sink(input valid, input pixel_value, input last_pixel, output ready);
endinterface

/* sv/otsu_thr_if.sv */
interface otsu_thr_if import otsu_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [LEVEL_W-1:0] threshold;

	modport source(output valid, output threshold, input ready);
	modport sink(input valid, input threshold, output ready);
endinterface

/* sv/otsu_mul.sv */
// Digit-serial multiplier: one DIGIT_W-bit digit of b per cycle, LSB first.
module otsu_mul import otsu_pkg::*; #(
	parameter int unsigned A_W     = 8,
	parameter int unsigned B_W     = 8,
	parameter int unsigned DIGIT_W = MUL_DIGIT_W
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [A_W-1:0]     a,
	input  logic [B_W-1:0]     b,
	output logic [A_W+B_W-1:0] p,
	output logic               busy
);

	localparam int unsigned STEPS = (B_W + DIGIT_W - 1) / DIGIT_W;
	localparam int unsigned BP_W  = STEPS * DIGIT_W;
	localparam int unsigned UW    = A_W + DIGIT_W;
	localparam int unsigned CNT_W = $clog2(STEPS + 1);

	logic [A_W-1:0]      a_q;
	logic [A_W+BP_W-1:0] prod_q;
	logic [A_W+BP_W-1:0] prod_nx;
	logic [UW-1:0]       upper;
	logic [CNT_W-1:0]    cnt_q;

	assign upper = UW'(prod_q[A_W+BP_W-1:BP_W]) + UW'(a_q) * UW'(prod_q[DIGIT_W-1:0]);

	generate
		if (STEPS > 1) begin : g_multi
			assign prod_nx = {upper, prod_q[BP_W-1:DIGIT_W]};
		end else begin : g_single
			assign prod_nx = upper;
		end
	endgenerate

	assign busy = cnt_q != '0;
	assign p    = prod_q[A_W+B_W-1:0];

	always_ff @(posedge clk) begin
		if (start) begin
			a_q    <= a;
			prod_q <= {{A_W{1'b0}}, BP_W'(b)};
		end else if (busy) begin
			prod_q <= prod_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(STEPS);
		end else if (busy) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

endmodule

/* sv/otsu_search.sv */
// Split search over bins 0..255; variance ratios compared by cross-multiplication.
module otsu_search import otsu_pkg::*; #(
	parameter int unsigned PIXEL_COUNT_BITS = PIX_CNT_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic                                ack,
	input  logic [PIXEL_COUNT_BITS-1:0]         bin_cnt,
	input  logic [PIXEL_COUNT_BITS-1:0]         n_all,
	input  logic [PIXEL_COUNT_BITS+LEVEL_W-1:0] s_all,
	output srch_stat_t                          stat
);

	localparam int unsigned CW  = PIXEL_COUNT_BITS;
	localparam int unsigned SW  = CW + LEVEL_W;
	localparam int unsigned CNW = CW + LEVEL_W;
	localparam int unsigned CSW = CW + 2 * LEVEL_W;
	localparam int unsigned AW  = SW + CW;
	localparam int unsigned NW  = 2 * AW;
	localparam int unsigned DW  = 2 * CW;
	localparam int unsigned LW  = NW + DW;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_READ  = 4'd1;
	localparam logic [3:0] S_ACC   = 4'd2;
	localparam logic [3:0] S_SPLIT = 4'd3;
	localparam logic [3:0] S_M1GO  = 4'd4;
	localparam logic [3:0] S_M1    = 4'd5;
	localparam logic [3:0] S_DIFF  = 4'd6;
	localparam logic [3:0] S_M2GO  = 4'd7;
	localparam logic [3:0] S_M2    = 4'd8;
	localparam logic [3:0] S_M3GO  = 4'd9;
	localparam logic [3:0] S_M3    = 4'd10;
	localparam logic [3:0] S_CMP   = 4'd11;
	localparam logic [3:0] S_DONE  = 4'd12;

	logic [3:0]         state_q;
	logic [LEVEL_W-1:0] lvl_q;
	logic               found_q;
	logic [CNW-1:0]     cum_n_q;
	logic [CSW-1:0]     cum_s_q;
	logic [CW-1:0]      n1_q;
	logic [CW-1:0]      n2_q;
	logic [SW-1:0]      s1_q;
	logic [SW-1:0]      s2_q;
	logic [AW-1:0]      d_q;
	logic [NW-1:0]      best_num_q;
	logic [DW-1:0]      best_den_q;
	logic [LEVEL_W-1:0] thr_q;

	logic [CSW-1:0] wsum;
	logic           skip;
	logic           s_clip;
	logic           take;
	logic           last_lvl;
	logic [AW-1:0]  prod_a;
	logic [AW-1:0]  prod_b;
	logic [DW-1:0]  den;
	logic [NW-1:0]  num;
	logic [LW-1:0]  lhs;
	logic [LW-1:0]  rhs;
	logic           busy_a;
	logic           busy_b;
	logic           busy_den;
	logic           busy_num;
	logic           busy_lhs;
	logic           busy_rhs;

	assign wsum     = CSW'(lvl_q) * CSW'(bin_cnt);
	assign skip     = (cum_n_q == '0) || (cum_n_q >= CNW'(n_all));
	assign s_clip   = cum_s_q >= CSW'(s_all);
	assign take     = !found_q || (lhs > rhs);
	assign last_lvl = lvl_q == LAST_LEVEL;

	assign stat.rd_en     = state_q == S_READ;
	assign stat.rd_addr   = lvl_q;
	assign stat.done      = state_q == S_DONE;
	assign stat.threshold = thr_q;

	otsu_mul #(.A_W(SW), .B_W(CW)) u_mul_a (
		.clk, .arst_n, .start(state_q == S_M1GO), .a(s1_q), .b(n2_q), .p(prod_a), .busy(busy_a)
	);
	otsu_mul #(.A_W(SW), .B_W(CW)) u_mul_b (
		.clk, .arst_n, .start(state_q == S_M1GO), .a(s2_q), .b(n1_q), .p(prod_b), .busy(busy_b)
	);
	otsu_mul #(.A_W(CW), .B_W(CW)) u_mul_den (
		.clk, .arst_n, .start(state_q == S_M1GO), .a(n1_q), .b(n2_q), .p(den), .busy(busy_den)
	);
	otsu_mul #(.A_W(AW), .B_W(AW)) u_mul_num (
		.clk, .arst_n, .start(state_q == S_M2GO), .a(d_q), .b(d_q), .p(num), .busy(busy_num)
	);
	otsu_mul #(.A_W(NW), .B_W(DW)) u_mul_lhs (
		.clk, .arst_n, .start(state_q == S_M3GO), .a(num), .b(best_den_q), .p(lhs),
		.busy(busy_lhs)
	);
	otsu_mul #(.A_W(NW), .B_W(DW)) u_mul_rhs (
		.clk, .arst_n, .start(state_q == S_M3GO), .a(best_num_q), .b(den), .p(rhs),
		.busy(busy_rhs)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			lvl_q   <= '0;
			found_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						lvl_q   <= '0;
						found_q <= 1'b0;
						state_q <= S_READ;
					end
				end
				S_READ:  state_q <= S_ACC;
				S_ACC:   state_q <= S_SPLIT;
				S_SPLIT: begin
					if (!skip) begin
						state_q <= S_M1GO;
					end else if (last_lvl) begin
						state_q <= S_DONE;
					end else begin
						lvl_q   <= lvl_q + LEVEL_W'(1);
						state_q <= S_READ;
					end
				end
				S_M1GO: state_q <= S_M1;
				S_M1: begin
					if (!(busy_a || busy_b || busy_den)) begin
						state_q <= S_DIFF;
					end
				end
				S_DIFF: state_q <= S_M2GO;
				S_M2GO: state_q <= S_M2;
				S_M2: begin
					if (!busy_num) begin
						state_q <= S_M3GO;
					end
				end
				S_M3GO: state_q <= S_M3;
				S_M3: begin
					if (!(busy_lhs || busy_rhs)) begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					if (take) begin
						found_q <= 1'b1;
					end
					if (last_lvl) begin
						state_q <= S_DONE;
					end else begin
						lvl_q   <= lvl_q + LEVEL_W'(1);
						state_q <= S_READ;
					end
				end
				S_DONE: begin
					if (ack) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cum_n_q <= '0;
					cum_s_q <= '0;
					thr_q   <= '0;
				end
			end
			S_ACC: begin
				cum_n_q <= cum_n_q + CNW'(bin_cnt);
				cum_s_q <= cum_s_q + wsum;
			end
			S_SPLIT: begin
				n1_q <= cum_n_q[CW-1:0];
				n2_q <= n_all - cum_n_q[CW-1:0];
				s1_q <= s_clip ? s_all : cum_s_q[SW-1:0];
				s2_q <= s_clip ? '0 : s_all - cum_s_q[SW-1:0];
			end
			S_DIFF: begin
				d_q <= (prod_a >= prod_b) ? prod_a - prod_b : prod_b - prod_a;
			end
			S_CMP: begin
				if (take) begin
					best_num_q <= num;
					best_den_q <= den;
					thr_q      <= lvl_q;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

/* sv/otsu_front.sv */
// Input side: takes pixel requests into a short queue for the histogram side.
module otsu_front import otsu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	otsu_pix_if.sink   pixels,
	input  logic       pop,
	output q_head_t    head
);

	localparam int unsigned PTR_W = $clog2(QDEPTH);

	pix_item_t        fifo_q [QDEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   cnt_q;
	logic             push;

	assign pixels.ready = cnt_q != (PTR_W+1)'(QDEPTH);
	assign push         = pixels.valid && pixels.ready;
	assign head.valid   = cnt_q != '0;
	assign head.item    = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= '{pixel_value: pixels.pixel_value, last_pixel: pixels.last_pixel};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + (PTR_W+1)'(1);
				2'b01:   cnt_q <= cnt_q - (PTR_W+1)'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

/* sv/otsu_back.sv */
// Histogram side: bin memory with read-modify-write, totals, search, result register.
module otsu_back import otsu_pkg::*; #(
	parameter int unsigned PIXEL_COUNT_BITS = PIX_CNT_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  q_head_t    head,
	output logic       pop,
	otsu_thr_if.source result
);

	localparam int unsigned CW = PIXEL_COUNT_BITS;
	localparam int unsigned SW = CW + LEVEL_W;
	localparam logic [CW-1:0] CMAX = {CW{1'b1}};
	localparam logic [SW-1:0] SMAX = {SW{1'b1}};

	localparam logic [1:0] M_RUN   = 2'd0;
	localparam logic [1:0] M_DRAIN = 2'd1;
	localparam logic [1:0] M_START = 2'd2;
	localparam logic [1:0] M_SRCH  = 2'd3;

	logic [1:0]         mode_q;
	logic [CW-1:0]      mem_q [LEVELS];
	logic [LEVELS-1:0]  bvld_q;
	logic [CW-1:0]      rd_q;
	logic               rv_q;
	logic               vld_s1;
	logic [LEVEL_W-1:0] pix_s1;
	logic               wr_vld_q;
	logic [LEVEL_W-1:0] wr_pix_q;
	logic [CW-1:0]      wr_cnt_q;
	logic [CW-1:0]      total_q;
	logic [SW-1:0]      lsum_q;
	logic               out_vld_q;
	logic [LEVEL_W-1:0] out_thr_q;

	logic               rd_en;
	logic [LEVEL_W-1:0] rd_addr;
	logic [CW-1:0]      bin_cnt;
	logic [CW-1:0]      old_cnt;
	logic [CW-1:0]      new_cnt;
	logic [SW:0]        lsum_ext;
	logic               ack;
	srch_stat_t         stat;

	assign pop     = head.valid && (mode_q == M_RUN);
	assign rd_en   = pop || stat.rd_en;
	assign rd_addr = pop ? head.item.pixel_value : stat.rd_addr;
	assign bin_cnt = rv_q ? rd_q : '0;
	// bypass the write that landed on the same edge as this read
	assign old_cnt  = (wr_vld_q && (wr_pix_q == pix_s1)) ? wr_cnt_q : bin_cnt;
	assign new_cnt  = (old_cnt == CMAX) ? old_cnt : old_cnt + CW'(1);
	assign lsum_ext = {1'b0, lsum_q} + (SW+1)'(pix_s1);
	assign ack      = (mode_q == M_SRCH) && stat.done && (!out_vld_q || result.ready);

	assign result.valid     = out_vld_q;
	assign result.threshold = out_thr_q;

	otsu_search #(.PIXEL_COUNT_BITS(PIXEL_COUNT_BITS)) u_search (
		.clk,
		.arst_n,
		.start   (mode_q == M_START),
		.ack     (ack),
		.bin_cnt (bin_cnt),
		.n_all   (total_q),
		.s_all   (lsum_q),
		.stat    (stat)
	);

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			mem_q[pix_s1] <= new_cnt;
		end
		if (rd_en) begin
			rd_q <= mem_q[rd_addr];
			rv_q <= bvld_q[rd_addr];
		end
		if (pop) begin
			pix_s1 <= head.item.pixel_value;
		end
		wr_pix_q <= pix_s1;
		wr_cnt_q <= new_cnt;
		if (ack) begin
			out_thr_q <= stat.threshold;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= M_RUN;
			vld_s1    <= 1'b0;
			wr_vld_q  <= 1'b0;
			bvld_q    <= '0;
			total_q   <= '0;
			lsum_q    <= '0;
			out_vld_q <= 1'b0;
		end else begin
			vld_s1   <= pop;
			wr_vld_q <= vld_s1;
			if (vld_s1) begin
				bvld_q[pix_s1] <= 1'b1;
				total_q        <= (total_q == CMAX) ? CMAX : total_q + CW'(1);
				lsum_q         <= lsum_ext[SW] ? SMAX : lsum_ext[SW-1:0];
			end
			if (ack) begin
				bvld_q  <= '0;
				total_q <= '0;
				lsum_q  <= '0;
			end
			case (mode_q)
				M_RUN: begin
					if (pop && head.item.last_pixel) begin
						mode_q <= M_DRAIN;
					end
				end
				M_DRAIN: mode_q <= M_START;
				M_START: mode_q <= M_SRCH;
				M_SRCH: begin
					if (ack) begin
						mode_q <= M_RUN;
					end
				end
				default: mode_q <= M_RUN;
			endcase
			if (ack) begin
				out_vld_q <= 1'b1;
			end else if (result.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

endmodule

/* sv/otsu_threshold_finder_top.sv */
// Channel   Dir  Payload                           Handshake
// pixels    in   pixel_value[7:0], last_pixel      valid / ready
// result    out  threshold[7:0]                    valid / ready
//
// One pixel request per cycle while the queue has room; a 4-entry queue sits in
// front of the histogram RMW. After the last pixel the back end drains and starts
// the bin scan; a bin that leaves a class empty is passed over without the
// multipliers, the others wait on the digit-serial multipliers of the search.
// arst_n clears control, totals and all bin valid bits; no sweep after reset.
// The queue takes pixels until full in the scan and while a result waits on ready.
module otsu_threshold_finder_top import otsu_pkg::*; #(
	parameter int unsigned PIXEL_COUNT_BITS = PIX_CNT_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	otsu_pix_if.sink   pixels,
	otsu_thr_if.source result
);

	q_head_t head;
	logic    pop;

	otsu_front u_front (
		.clk,
		.arst_n,
		.pixels (pixels),
		.pop    (pop),
		.head   (head)
	);

	otsu_back #(.PIXEL_COUNT_BITS(PIXEL_COUNT_BITS)) u_back (
		.clk,
		.arst_n,
		.head   (head),
		.pop    (pop),
		.result (result)
	);

endmodule

/* sv/otsu_chk.sv */
`include "otsu_threshold_finder_top_assert.svh"

module otsu_chk import otsu_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               in_last,
	input logic               out_valid,
	input logic               out_ready,
	input logic [LEVEL_W-1:0] threshold
);

	// frames in flight: queue, one in the search, one in the result register
	localparam int unsigned PEND_MAX = QDEPTH + 2;
	localparam int unsigned PEND_W   = $clog2(PEND_MAX + 2);

	logic [PEND_W-1:0] pend_q;
	logic              last_acc;
	logic              out_acc;

	assign last_acc = in_valid && in_ready && in_last;
	assign out_acc  = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			case ({last_acc, out_acc})
				2'b10:   pend_q <= pend_q + PEND_W'(1);
				2'b01:   pend_q <= pend_q - PEND_W'(1);
				default: pend_q <= pend_q;
			endcase
		end
	end

	`OTSU_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(threshold), "result changed while stalled")
	`OTSU_ASSERT_NOW(a_out_has_frame, out_valid, pend_q != '0, "result request without a pending frame")
	`OTSU_ASSERT_NOW(a_pend_bound, 1'b1, pend_q <= PEND_W'(PEND_MAX), "too many frames in flight")

endmodule

bind otsu_threshold_finder_top otsu_chk u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (pixels.valid),
	.in_ready  (pixels.ready),
	.in_last   (pixels.last_pixel),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.threshold (result.threshold)
);

/* verif/otsu_threshold_finder_top_tb.sv */
`timescale 1ns / 1ps

module otsu_threshold_finder_top_tb import otsu_pkg::*; ();

	localparam int unsigned CNT_BITS       = 8;
	localparam int unsigned RANDOM_ITEMS   = 2000;
	localparam int unsigned IDLE_PCT       = 12;
	localparam int unsigned WATCHDOG_LIMIT = 20000;
	localparam int unsigned DRAIN_CYCLES   = 100;
	localparam int          LAST_MARK      = 256;

	class otsu_scoreboard;
		longint unsigned    bin_cnt[LEVELS];
		longint unsigned    pix_total;
		longint unsigned    grey_sum;
		logic [LEVEL_W-1:0] thr_expected[$];
		int unsigned        errors;

		function longint unsigned sat_add(longint unsigned a, longint unsigned b,
				longint unsigned lim);
			return (b >= lim || a >= lim - b) ? lim : a + b;
		endfunction

		// exact between-class variance search, first strict maximum wins
		function logic [LEVEL_W-1:0] best_split();
			longint unsigned    cum_n, cum_s, n1, n2, s1, s2;
			logic [255:0]       a, b, d, num, den, best_num, best_den;
			bit                 found;
			logic [LEVEL_W-1:0] thr;
			cum_n    = 0;
			cum_s    = 0;
			found    = 1'b0;
			thr      = '0;
			best_num = '0;
			best_den = '0;
			for (int i = 0; i < LEVELS; i++) begin
				cum_n += bin_cnt[i];
				cum_s += longint'(i) * bin_cnt[i];
				if (cum_n == 0 || cum_n >= pix_total)
					continue;
				n1  = cum_n;
				n2  = pix_total - n1;
				s1  = (cum_s < grey_sum) ? cum_s : grey_sum;
				s2  = grey_sum - s1;
				a   = 256'(s1) * 256'(n2);
				b   = 256'(s2) * 256'(n1);
				d   = (a >= b) ? a - b : b - a;
				num = d * d;
				den = 256'(n1 * n2);
				if (found && num * best_den <= best_num * den)
					continue;
				found    = 1'b1;
				best_num = num;
				best_den = den;
				thr      = LEVEL_W'(i);
			end
			return thr;
		endfunction

		function void add_pixel(logic [LEVEL_W-1:0] pv, logic lp);
			longint unsigned cnt_max;
			longint unsigned sum_max;
			cnt_max     = (longint'(1) << CNT_BITS) - 1;
			sum_max     = (longint'(1) << (CNT_BITS + 8)) - 1;
			bin_cnt[pv] = sat_add(bin_cnt[pv], 1, cnt_max);
			pix_total   = sat_add(pix_total, 1, cnt_max);
			grey_sum    = sat_add(grey_sum, longint'(pv), sum_max);
			if (lp) begin
				thr_expected.push_back(best_split());
				foreach (bin_cnt[i])
					bin_cnt[i] = 0;
				pix_total = 0;
				grey_sum  = 0;
			end
		endfunction

		function void check_threshold(logic [LEVEL_W-1:0] thr);
			logic [LEVEL_W-1:0] want;
			if (thr_expected.size() == 0) begin
				errors++;
				$display("%0t: unexpected threshold, expected none, actual %0d", $time, thr);
			end else begin
				want = thr_expected.pop_front();
				if (thr !== want) begin
					errors++;
					$display("%0t: threshold mismatch, expected %0d, actual %0d",
						$time, want, thr);
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bit   calm;
	int unsigned idle_cycles;

	otsu_scoreboard sb = new;

	otsu_pix_if pix_bus ();
	otsu_thr_if thr_bus ();

	otsu_threshold_finder_top #(
		.PIXEL_COUNT_BITS(CNT_BITS)
	) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.pixels (pix_bus),
		.result (thr_bus)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(negedge clk)
		thr_bus.ready <= calm || ($urandom_range(99) >= IDLE_PCT);

	always @(posedge clk) begin
		if (arst_n) begin
			if (thr_bus.valid && thr_bus.ready)
				sb.check_threshold(thr_bus.threshold);
			if (pix_bus.valid && pix_bus.ready)
				sb.add_pixel(pix_bus.pixel_value, pix_bus.last_pixel);
			if ((thr_bus.valid && thr_bus.ready) || (pix_bus.valid && pix_bus.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("otsu_threshold_finder_top_tb failed");
				$finish;
			end
		end
	end

	task automatic send_pixel(input logic [LEVEL_W-1:0] pv, input logic lp);
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			pix_bus.valid <= 1'b0;
			@(negedge clk);
		end
		pix_bus.valid       <= 1'b1;
		pix_bus.pixel_value <= pv;
		pix_bus.last_pixel  <= lp;
		do
			@(posedge clk);
		while (!pix_bus.ready);
		@(negedge clk);
	endtask

	initial begin
		int unsigned        sent;
		int unsigned        len;
		int unsigned        kind;
		int unsigned        width;
		int unsigned        base;
		logic [LEVEL_W-1:0] pv;
		int                 directed[$];
		directed = {LAST_MARK + 0, LAST_MARK + 255, 0, LAST_MARK + 255,
			128, 128, LAST_MARK + 128, 0, 100, LAST_MARK + 200, 5, LAST_MARK + 6,
			255, 0, 170, LAST_MARK + 85, 1, 2, 4, 8, 16, 32, 64, LAST_MARK + 128};
		arst_n              = 1'b0;
		calm                = 1'b0;
		idle_cycles         = 0;
		pix_bus.valid       = 1'b0;
		pix_bus.pixel_value = '0;
		pix_bus.last_pixel  = 1'b0;
		thr_bus.ready       = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// single pixels, one-bin frames, ties, extreme levels
		foreach (directed[k])
			send_pixel(LEVEL_W'(directed[k]), directed[k] >= LAST_MARK);

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			calm = (sent >= 900 && sent < 1300);
			if ($urandom_range(99) < 3) begin
				// long frames push the counters into saturation
				len  = $urandom_range(320, 256);
				kind = $urandom_range(1);
				base = $urandom_range(3);
				for (int k = 0; k < len; k++) begin
					if (kind == 0)
						pv = ($urandom_range(9) == 0) ? LEVEL_W'(base) : LAST_LEVEL;
					else
						pv = $urandom_range(1) ? LAST_LEVEL : LEVEL_W'($urandom_range(15));
					send_pixel(pv, k == len - 1);
				end
			end else begin
				len = $urandom_range(40, 1);
				case ($urandom_range(3))
					0: width = 1;
					1: width = 8;
					2: width = 32;
					default: width = LEVELS;
				endcase
				base = $urandom_range(LEVELS - width);
				for (int k = 0; k < len; k++)
					send_pixel(LEVEL_W'(base + $urandom_range(width - 1)), k == len - 1);
			end
			sent += len;
		end
		calm = 1'b0;
		// trailing pixels with no frame end
		len = $urandom_range(5, 1);
		for (int k = 0; k < len; k++)
			send_pixel(LEVEL_W'($urandom_range(255)), 1'b0);
		pix_bus.valid <= 1'b0;

		while (sb.thr_expected.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("otsu_threshold_finder_top_tb passed");
		else
			$display("otsu_threshold_finder_top_tb failed");
		$finish;
	end

endmodule

/* otsu_threshold_finder_top.f */
+incdir+sv
sv/otsu_pkg.sv
sv/otsu_pix_if.sv
sv/otsu_thr_if.sv
sv/otsu_mul.sv
sv/otsu_search.sv
sv/otsu_front.sv
sv/otsu_back.sv
sv/otsu_threshold_finder_top.sv
sv/otsu_chk.sv
verif/otsu_threshold_finder_top_tb.sv
